// ===== rtl/lie_pkg.sv =====
`timescale 1ns / 1ps

package lie_pkg;

    // Coordinate width taken from each point field
    localparam int COORD_WIDTH_DEF = 16;

    // Clock edges from the accepting edge to the edge that takes the result
    localparam int LATENCY = 96;

    // Luminance weights, Q0.16, summing to exactly one
    localparam logic [15:0] W_RED     = 16'd13763;
    localparam logic [15:0] W_GREEN   = 16'd47186;
    localparam logic [15:0] W_BLUE    = 16'd4587;
    localparam logic [31:0] LUM_ROUND = 32'd32768;

    localparam logic [14:0] ONE_Q14 = 15'd16384;

    // Light kinds
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_SPOT  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_KIND      = 3'd0;
    localparam logic [2:0] REG_LUM_RED   = 3'd1;
    localparam logic [2:0] REG_LUM_GREEN = 3'd2;
    localparam logic [2:0] REG_LUM_BLUE  = 3'd3;
    localparam logic [2:0] REG_POSITION  = 3'd4;
    localparam logic [2:0] REG_DIRECTION = 3'd5;
    localparam logic [2:0] REG_COS_INNER = 3'd6;
    localparam logic [2:0] REG_COS_OUTER = 3'd7;

    // How an item is finished
    typedef enum logic [1:0] {
        MODE_FLAT,
        MODE_POINT,
        MODE_SPOT,
        MODE_ZERO
    } t_mode;

    typedef struct packed {
        logic [1:0]          kind;
        logic [15:0]         lum;
        logic [47:0]         pos;
        logic [47:0]         dir;
        logic signed [15:0]  ci;
        logic signed [15:0]  co;
    } t_cfg;

    typedef struct packed {
        logic        vld;
        t_mode       mode;
        logic [35:0] d2;
        logic [15:0] lum;
        logic        dneg;
        logic [41:0] dmag;
        logic [25:0] len;
        logic [14:0] f;
    } t_item;

endpackage

// ===== rtl/lie_cfg.sv =====
`timescale 1ns / 1ps

module lie_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [2:0]    i_index,
    input  logic [47:0]   i_data,
    output lie_pkg::t_cfg o_cfg
);

    logic [1:0]  r_kind;
    logic [15:0] r_red;
    logic [15:0] r_green;
    logic [15:0] r_blue;
    logic [47:0] r_pos;
    logic [47:0] r_dir;
    logic [15:0] r_ci;
    logic [15:0] r_co;
    logic [31:0] r_pr_r;
    logic [31:0] r_pr_g;
    logic [31:0] r_pr_b;
    logic [31:0] r_lum_sum;

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= lie_pkg::KIND_POINT;
            r_red   <= 16'd256;
            r_green <= 16'd256;
            r_blue  <= 16'd256;
            r_pos   <= '0;
            r_dir   <= '0;
            r_ci    <= 16'd16384;
            r_co    <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                lie_pkg::REG_KIND:      r_kind  <= i_data[1:0];
                lie_pkg::REG_LUM_RED:   r_red   <= i_data[15:0];
                lie_pkg::REG_LUM_GREEN: r_green <= i_data[15:0];
                lie_pkg::REG_LUM_BLUE:  r_blue  <= i_data[15:0];
                lie_pkg::REG_POSITION:  r_pos   <= i_data;
                lie_pkg::REG_DIRECTION: r_dir   <= i_data;
                lie_pkg::REG_COS_INNER: r_ci    <= i_data[15:0];
                lie_pkg::REG_COS_OUTER: r_co    <= i_data[15:0];
            endcase
        end
    end

    // Weigh the colour channels, then sum with rounding
    always_ff @(posedge i_clk) begin
        r_pr_r    <= 32'(lie_pkg::W_RED) * 32'(r_red);
        r_pr_g    <= 32'(lie_pkg::W_GREEN) * 32'(r_green);
        r_pr_b    <= 32'(lie_pkg::W_BLUE) * 32'(r_blue);
        r_lum_sum <= r_pr_r + r_pr_g + r_pr_b + lie_pkg::LUM_ROUND;
    end

    always_comb begin
        o_cfg.kind = r_kind;
        o_cfg.lum  = r_lum_sum[31:16];
        o_cfg.pos  = r_pos;
        o_cfg.dir  = r_dir;
        o_cfg.ci   = signed'(r_ci);
        o_cfg.co   = signed'(r_co);
    end

endmodule

// ===== rtl/lie_front.sv =====
`timescale 1ns / 1ps

module lie_front #(
    parameter int COORD_WIDTH = lie_pkg::COORD_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [15:0]    i_px,
    input  logic [15:0]    i_py,
    input  logic [15:0]    i_pz,
    input  lie_pkg::t_cfg  i_cfg,
    output lie_pkg::t_item o_item
);

    localparam int SW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;

    logic [15:0]        pt     [0:2];
    logic signed [16:0] pc     [0:2];
    logic signed [17:0] n_d    [0:2];
    logic signed [35:0] sq_full[0:2];
    logic signed [33:0] n_pr   [0:2];
    logic [35:0]        d2;
    logic signed [35:0] dot;
    logic [35:0]        mag;
    lie_pkg::t_item     n_item;

    logic               r_v1;
    logic signed [17:0] r_d [0:2];
    logic               r_v2;
    logic [34:0]        r_sq[0:2];
    logic signed [33:0] r_pr[0:2];
    lie_pkg::t_item     r_item;

    // Offset from the point to the light, per axis
    always_comb begin
        pt[0] = i_px;
        pt[1] = i_py;
        pt[2] = i_pz;
        for (int i = 0; i < 3; i++) begin
            if (COORD_WIDTH > 16) begin
                pc[i] = signed'({1'b0, pt[i]});
            end else begin
                pc[i] = signed'({{(17 - SW){pt[i][SW - 1]}}, pt[i][SW - 1:0]});
            end
            n_d[i] = 18'(signed'(i_cfg.pos[16 * i +: 16])) - 18'(pc[i]);
        end
    end

    // Squares and axis products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_full[i] = 36'(r_d[i]) * 36'(r_d[i]);
            n_pr[i]    = 34'(r_d[i]) * 34'(signed'(i_cfg.dir[16 * i +: 16]));
        end
    end

    // Sum, classify and split the dot product into sign and magnitude
    always_comb begin
        d2  = 36'(r_sq[0]) + 36'(r_sq[1]) + 36'(r_sq[2]);
        dot = 36'(r_pr[0]) + 36'(r_pr[1]) + 36'(r_pr[2]);
        mag = (dot < 0) ? 36'(-dot) : 36'(dot);
        n_item      = '0;
        n_item.vld  = r_v2;
        n_item.d2   = d2;
        n_item.lum  = i_cfg.lum;
        n_item.dneg = (dot < 0);
        n_item.dmag = {mag[33:0], 8'd0};
        priority if (i_cfg.kind != lie_pkg::KIND_POINT && i_cfg.kind != lie_pkg::KIND_SPOT) begin
            n_item.mode = lie_pkg::MODE_FLAT;
        end else if (d2 == '0) begin
            n_item.mode = lie_pkg::MODE_ZERO;
        end else if (i_cfg.kind == lie_pkg::KIND_POINT) begin
            n_item.mode = lie_pkg::MODE_POINT;
        end else begin
            n_item.mode = lie_pkg::MODE_SPOT;
        end
    end

    // Advance the three front stages
    always_ff @(posedge i_clk) begin
        r_d  <= n_d;
        r_sq <= '{sq_full[0][34:0], sq_full[1][34:0], sq_full[2][34:0]};
        r_pr <= n_pr;
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_item.vld <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== rtl/lie_sqrt.sv =====
`timescale 1ns / 1ps

module lie_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lie_pkg::t_item i_item,
    output lie_pkg::t_item o_item
);

    localparam int STEPS = 26;

    lie_pkg::t_item s_item[0:STEPS];
    logic [26:0]    s_rem [0:STEPS];
    logic [25:0]    s_root[0:STEPS];
    lie_pkg::t_item n_item[1:STEPS];
    logic [26:0]    n_rem [1:STEPS];
    logic [25:0]    n_root[1:STEPS];
    lie_pkg::t_item r_item[1:STEPS];
    logic [26:0]    r_rem [1:STEPS];
    logic [25:0]    r_root[1:STEPS];

    logic [51:0]    v    [0:STEPS - 1];
    logic [27:0]    rsh  [0:STEPS - 1];
    logic [27:0]    trial[0:STEPS - 1];

    // One root bit per stage, two radicand bits shifted in each time
    always_comb begin
        s_item[0] = i_item;
        s_rem[0]  = '0;
        s_root[0] = '0;
        for (int k = 1; k <= STEPS; k++) begin
            s_item[k] = r_item[k];
            s_rem[k]  = r_rem[k];
            s_root[k] = r_root[k];
        end
        for (int k = 0; k < STEPS; k++) begin
            v[k]     = {s_item[k].d2, 16'd0};
            rsh[k]   = {s_rem[k][25:0], v[k][2 * (STEPS - 1 - k) +: 2]};
            trial[k] = {s_root[k], 2'b01};
            n_item[k + 1] = s_item[k];
            if (rsh[k] >= trial[k]) begin
                n_rem[k + 1]  = 27'(rsh[k] - trial[k]);
                n_root[k + 1] = {s_root[k][24:0], 1'b1};
            end else begin
                n_rem[k + 1]  = 27'(rsh[k]);
                n_root[k + 1] = {s_root[k][24:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        if (!i_rst_n) begin
            for (int k = 1; k <= STEPS; k++) begin
                r_item[k].vld <= 1'b0;
            end
        end else begin
            r_item <= n_item;
        end
    end

    always_comb begin
        o_item     = s_item[STEPS];
        o_item.len = s_root[STEPS];
    end

endmodule

// ===== rtl/lie_spot.sv =====
`timescale 1ns / 1ps

module lie_spot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lie_pkg::t_cfg  i_cfg,
    input  lie_pkg::t_item i_item,
    output lie_pkg::t_item o_item
);

    localparam int TSTEPS = 16;
    localparam int FSTEPS = 14;

    // Angle quotient stages
    lie_pkg::t_item r_ti[0:TSTEPS];
    logic [25:0]    r_tr[0:TSTEPS];
    logic [15:0]    r_tq[0:TSTEPS];
    logic           r_ts[0:TSTEPS];
    lie_pkg::t_item n_ti[1:TSTEPS];
    logic [25:0]    n_tr[1:TSTEPS];
    logic [15:0]    n_tq[1:TSTEPS];
    logic [26:0]    t_rsh[0:TSTEPS - 1];
    logic           t_ge [0:TSTEPS - 1];

    // Falloff quotient stages
    lie_pkg::t_item r_fi  [0:FSTEPS];
    logic [15:0]    r_fr  [0:FSTEPS];
    logic [13:0]    r_fq  [0:FSTEPS];
    logic           r_fsel[0:FSTEPS];
    logic [14:0]    r_ffix[0:FSTEPS];
    logic [15:0]    n_fr  [1:FSTEPS];
    logic [13:0]    n_fq  [1:FSTEPS];
    logic [16:0]    f_rsh [0:FSTEPS - 1];
    logic           f_ge  [0:FSTEPS - 1];

    logic signed [16:0] den;
    logic [16:0]        tmag;
    logic signed [17:0] theta;
    logic signed [18:0] tmc;
    logic [15:0]        n_fr0;
    logic               n_fsel0;
    logic [14:0]        n_ffix0;

    assign den = 17'(i_cfg.ci) - 17'(i_cfg.co);

    // Angle: (dot << 8) / len, magnitude clipped at four, one bit a stage
    always_comb begin
        for (int k = 0; k < TSTEPS; k++) begin
            t_rsh[k] = {r_tr[k], r_ti[k].dmag[TSTEPS - 1 - k]};
            t_ge[k]  = (t_rsh[k] >= {1'b0, r_ti[k].len});
            n_ti[k + 1] = r_ti[k];
            n_tr[k + 1] = t_ge[k] ? 26'(t_rsh[k] - {1'b0, r_ti[k].len}) : t_rsh[k][25:0];
            n_tq[k + 1] = {r_tq[k][14:0], t_ge[k]};
        end
    end

    // Resolve clamped and stepped falloffs; set up the fractional divide
    always_comb begin
        tmag  = r_ts[TSTEPS] ? 17'h10000 : {1'b0, r_tq[TSTEPS]};
        theta = r_ti[TSTEPS].dneg ? -signed'({1'b0, tmag}) : signed'({1'b0, tmag});
        tmc   = 19'(theta) - 19'(i_cfg.co);
        n_fr0   = tmc[15:0];
        n_fsel0 = 1'b0;
        n_ffix0 = '0;
        priority if (den <= 0) begin
            n_ffix0 = (theta >= 18'(i_cfg.co)) ? lie_pkg::ONE_Q14 : '0;
        end else if (theta <= 18'(i_cfg.co)) begin
            n_ffix0 = '0;
        end else if (tmc >= 19'(den)) begin
            n_ffix0 = lie_pkg::ONE_Q14;
        end else begin
            n_fsel0 = 1'b1;
        end
    end

    // Falloff fraction, one bit a stage
    always_comb begin
        for (int k = 0; k < FSTEPS; k++) begin
            f_rsh[k] = {r_fr[k], 1'b0};
            f_ge[k]  = (f_rsh[k] >= {1'b0, den[15:0]});
            n_fr[k + 1] = f_ge[k] ? 16'(f_rsh[k] - {1'b0, den[15:0]}) : f_rsh[k][15:0];
            n_fq[k + 1] = {r_fq[k][12:0], f_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tr[0] <= i_item.dmag[41:16];
        r_tq[0] <= '0;
        r_ts[0] <= (i_item.dmag[41:16] >= i_item.len);
        for (int k = 1; k <= TSTEPS; k++) begin
            r_tr[k] <= n_tr[k];
            r_tq[k] <= n_tq[k];
            r_ts[k] <= r_ts[k - 1];
        end
        r_fr[0]   <= n_fr0;
        r_fq[0]   <= '0;
        r_fsel[0] <= n_fsel0;
        r_ffix[0] <= n_ffix0;
        for (int k = 1; k <= FSTEPS; k++) begin
            r_fr[k]   <= n_fr[k];
            r_fq[k]   <= n_fq[k];
            r_fsel[k] <= r_fsel[k - 1];
            r_ffix[k] <= r_ffix[k - 1];
        end
        if (!i_rst_n) begin
            for (int k = 0; k <= TSTEPS; k++) begin
                r_ti[k].vld <= 1'b0;
            end
            for (int k = 0; k <= FSTEPS; k++) begin
                r_fi[k].vld <= 1'b0;
            end
        end else begin
            r_ti[0] <= i_item;
            for (int k = 1; k <= TSTEPS; k++) begin
                r_ti[k] <= n_ti[k];
            end
            r_fi[0] <= r_ti[TSTEPS];
            for (int k = 1; k <= FSTEPS; k++) begin
                r_fi[k] <= r_fi[k - 1];
            end
        end
    end

    always_comb begin
        o_item   = r_fi[FSTEPS];
        o_item.f = r_fsel[FSTEPS] ? {1'b0, r_fq[FSTEPS]} : r_ffix[FSTEPS];
    end

endmodule

// ===== rtl/lie_div.sv =====
`timescale 1ns / 1ps

module lie_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lie_pkg::t_item i_item,
    output logic           o_strobe,
    output logic [31:0]    o_intensity,
    output logic           o_saturated
);

    localparam int STEPS = 32;

    lie_pkg::t_item r_ai;
    logic [30:0]    r_prod;

    lie_pkg::t_item r_bi[0:STEPS];
    logic [35:0]    r_br[0:STEPS];
    logic [31:0]    r_bl[0:STEPS];
    logic [31:0]    r_bq[0:STEPS];
    logic           r_bs[0:STEPS];
    logic [35:0]    n_br[1:STEPS];
    logic [31:0]    n_bq[1:STEPS];
    logic [36:0]    rsh [0:STEPS - 1];
    logic           ge  [0:STEPS - 1];

    logic [39:0]    num;
    logic           n_sat0;
    logic [31:0]    n_int;
    logic           n_osat;

    logic           r_strobe;
    logic [31:0]    r_int;
    logic           r_sat;

    // Numerator and overflow test
    always_comb begin
        if (r_ai.mode == lie_pkg::MODE_POINT) begin
            num = {r_ai.lum, 24'd0};
        end else begin
            num = {r_prod[29:0], 10'd0};
        end
        n_sat0 = (r_ai.d2[35:8] == '0) && (num[39:32] >= r_ai.d2[7:0]);
    end

    // Long division by the squared distance, one quotient bit a stage
    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            rsh[k] = {r_br[k], r_bl[k][STEPS - 1 - k]};
            ge[k]  = (rsh[k] >= {1'b0, r_bi[k].d2});
            n_br[k + 1] = ge[k] ? 36'(rsh[k] - {1'b0, r_bi[k].d2}) : rsh[k][35:0];
            n_bq[k + 1] = {r_bq[k][30:0], ge[k]};
        end
    end

    // Pick the result for the kind of light
    always_comb begin
        unique case (r_bi[STEPS].mode)
            lie_pkg::MODE_FLAT: begin
                n_int  = {8'd0, r_bi[STEPS].lum, 8'd0};
                n_osat = 1'b0;
            end
            lie_pkg::MODE_ZERO: begin
                n_int  = '1;
                n_osat = 1'b1;
            end
            lie_pkg::MODE_POINT, lie_pkg::MODE_SPOT: begin
                n_int  = r_bs[STEPS] ? '1 : r_bq[STEPS];
                n_osat = r_bs[STEPS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= 31'(i_item.lum) * 31'(i_item.f);
        r_br[0] <= 36'(num[39:32]);
        r_bl[0] <= num[31:0];
        r_bq[0] <= '0;
        r_bs[0] <= n_sat0;
        for (int k = 1; k <= STEPS; k++) begin
            r_br[k] <= n_br[k];
            r_bl[k] <= r_bl[k - 1];
            r_bq[k] <= n_bq[k];
            r_bs[k] <= r_bs[k - 1];
        end
        r_int <= n_int;
        r_sat <= n_osat;
        if (!i_rst_n) begin
            r_ai.vld <= 1'b0;
            for (int k = 0; k <= STEPS; k++) begin
                r_bi[k].vld <= 1'b0;
            end
            r_strobe <= 1'b0;
        end else begin
            r_ai    <= i_item;
            r_bi[0] <= r_ai;
            for (int k = 1; k <= STEPS; k++) begin
                r_bi[k] <= r_bi[k - 1];
            end
            r_strobe <= r_bi[STEPS].vld;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_intensity = r_int;
    assign o_saturated = r_sat;

endmodule

// ===== rtl/light_intensity_estimator_unit.sv =====
// A taken start flows through front, square root, spot and divider to a registered o_strobe.
// Throughput: one point per cycle unless busy; every stage advancing; the longest span is
// the 32-stage long division by the squared distance, after a 26-stage square root.
// Reset: synchronous, active low; clears every stage valid, busy is high for one cycle after.
// Results cannot be held off: each appears for exactly one cycle.
`timescale 1ns / 1ps

module light_intensity_estimator_unit #(
    parameter int COORD_WIDTH = lie_pkg::COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    input  logic [15:0] i_point_z,
    output logic        o_strobe,
    output logic [31:0] o_intensity,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic           r_live;
    lie_pkg::t_cfg  cfg;
    lie_pkg::t_item front_item;
    lie_pkg::t_item sqrt_item;
    lie_pkg::t_item spot_item;

    // Hold off transfers for one cycle out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign busy        = !r_live;
    assign o_cfg_ready = r_live;

    lie_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lie_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !busy),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_pz    (i_point_z),
        .i_cfg   (cfg),
        .o_item  (front_item)
    );

    lie_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (front_item),
        .o_item  (sqrt_item)
    );

    lie_spot u_spot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (sqrt_item),
        .o_item  (spot_item)
    );

    lie_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (spot_item),
        .o_strobe    (o_strobe),
        .o_intensity (o_intensity),
        .o_saturated (o_saturated)
    );

    // A clipped result always reads full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |-> (o_intensity == 32'hFFFF_FFFF))
        else $error("saturated result not at full scale");

    // Every result stems from a transfer a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, lie_pkg::LATENCY))
        else $error("result without matching transfer");

    // Reset drains the pipeline
    a_reset_drain: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] KIND_FLAT   = 2'd0;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] intensity;
        logic        saturated;
    } t_light_res;

    // Light settings copy, predictor and queue of expected intensities
    class t_light_scoreboard;
        logic [1:0]  kind;
        logic [15:0] lum_r, lum_g, lum_b;
        logic [47:0] pos, dir;
        logic [15:0] ci, co;
        t_light_res  expected_q[$];
        int          errors;

        function new();
            kind = lie_pkg::KIND_POINT;
            lum_r = 16'd256;
            lum_g = 16'd256;
            lum_b = 16'd256;
            pos = '0;
            dir = '0;
            ci = 16'd16384;
            co = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] data);
            case (idx)
                lie_pkg::REG_KIND:      kind = data[1:0];
                lie_pkg::REG_LUM_RED:   lum_r = data[15:0];
                lie_pkg::REG_LUM_GREEN: lum_g = data[15:0];
                lie_pkg::REG_LUM_BLUE:  lum_b = data[15:0];
                lie_pkg::REG_POSITION:  pos = data;
                lie_pkg::REG_DIRECTION: dir = data;
                lie_pkg::REG_COS_INNER: ci = data[15:0];
                lie_pkg::REG_COS_OUTER: co = data[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Work out the attenuated intensity for one point
        function t_light_res attenuate(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
            t_light_res      res;
            longint          d[3];
            longint          p[3];
            longint          dot, len, theta, f, lci, lco;
            longint unsigned lum, d2, num, q;
            p[0] = longint'($signed(px));
            p[1] = longint'($signed(py));
            p[2] = longint'($signed(pz));
            lum = (64'd13763 * lum_r + 64'd47186 * lum_g + 64'd4587 * lum_b + 64'd32768) >> 16;
            d2 = 0;
            dot = 0;
            for (int i = 0; i < 3; i++) begin
                d[i] = longint'($signed(pos[16*i +: 16])) - p[i];
                d2 += longint'(d[i] * d[i]);
                dot += d[i] * longint'($signed(dir[16*i +: 16]));
            end
            if (kind != lie_pkg::KIND_POINT && kind != lie_pkg::KIND_SPOT) begin
                res.intensity = 32'(lum << 8);
                res.saturated = 1'b0;
                return res;
            end
            if (d2 == 0) begin
                res.intensity = '1;
                res.saturated = 1'b1;
                return res;
            end
            if (kind == lie_pkg::KIND_POINT) begin
                num = lum << 24;
            end else begin
                lci = longint'($signed(ci));
                lco = longint'($signed(co));
                len = longint'(int_sqrt(d2 << 16));
                theta = (dot * 256) / len;
                if (lci > lco) begin
                    if (theta <= lco) begin
                        f = 0;
                    end else begin
                        f = ((theta - lco) * 16384) / (lci - lco);
                        if (f > 16384) f = 16384;
                    end
                end else begin
                    f = (theta >= lco) ? 16384 : 0;
                end
                num = (lum * longint'(f)) << 10;
            end
            q = num / d2;
            if (q > 64'hFFFF_FFFF) begin
                res.intensity = '1;
                res.saturated = 1'b1;
            end else begin
                res.intensity = q[31:0];
                res.saturated = 1'b0;
            end
            return res;
        endfunction

        function void note_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
            expected_q.push_back(attenuate(px, py, pz));
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [31:0] inten, logic sat);
            t_light_res e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %h/%b", inten, sat));
                return;
            end
            e = expected_q.pop_front();
            if (inten !== e.intensity)
                report($sformatf("intensity %h, want %h", inten, e.intensity));
            if (sat !== e.saturated)
                report($sformatf("saturated %b, want %b", sat, e.saturated));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic        o_strobe;
    logic [31:0] o_intensity;
    logic        o_saturated;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    t_light_scoreboard sb = new();
    bit                no_gaps = 1'b0;

    light_intensity_estimator_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // Record accepted transfers on every channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (start && !busy) sb.note_point(i_point_x, i_point_y, i_point_z);
            if (o_strobe) sb.check_result(o_intensity, o_saturated);
        end
    end

    task write_reg(logic [2:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Program every register, then release the channel
    task set_light(logic [1:0] kind, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                   logic [47:0] pos, logic [47:0] dir, logic [15:0] ci, logic [15:0] co);
        write_reg(lie_pkg::REG_KIND, 48'(kind));
        write_reg(lie_pkg::REG_LUM_RED, 48'(r));
        write_reg(lie_pkg::REG_LUM_GREEN, 48'(g));
        write_reg(lie_pkg::REG_LUM_BLUE, 48'(b));
        write_reg(lie_pkg::REG_POSITION, pos);
        write_reg(lie_pkg::REG_DIRECTION, dir);
        write_reg(lie_pkg::REG_COS_INNER, 48'(ci));
        write_reg(lie_pkg::REG_COS_OUTER, 48'(co));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        start <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        do @(posedge i_clk); while (busy);
        if (!no_gaps && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    // Drop start and hold until every expected result has come
    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function logic [15:0] rand_cos();
        case ($urandom_range(4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed(17'($urandom_range(32768))) - 17'sd16384);
        endcase
    endfunction

    function logic [15:0] rand_lum();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function logic [47:0] rand_dir();
        logic [15:0] h[3];
        int          ax;
        if ($urandom_range(3) == 0) return {16'($urandom), 16'($urandom), 16'($urandom)};
        ax = $urandom_range(2);
        for (int i = 0; i < 3; i++) h[i] = 16'($signed(12'($urandom)));
        h[ax] = ($urandom_range(1) != 0) ? 16'sd16384 : -16'sd16384;
        return {h[2], h[1], h[0]};
    endfunction

    // Points near the light mostly, some on it, some anywhere
    task rand_point(logic [47:0] pos);
        logic [15:0] c[3];
        int          sel;
        sel = $urandom_range(9);
        for (int i = 0; i < 3; i++) begin
            if (sel == 0) c[i] = pos[16*i +: 16];
            else if (sel < 4) c[i] = 16'($urandom);
            else c[i] = pos[16*i +: 16] + 16'($signed(11'($urandom)) >>> $urandom_range(10));
        end
        send_point(c[0], c[1], c[2]);
    endtask

    initial begin
        logic [47:0] rpos;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: point light at the origin
        send_point(16'h0000, 16'h0000, 16'h0000);
        send_point(16'h0001, 16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h8000, 16'h7FFF, 16'h0100);
        drain();

        // Directional and unused kind at extreme luminance
        set_light(KIND_FLAT, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, '0, 16'd16384, '0);
        send_point(16'h1234, 16'h8000, 16'h7FFF);
        send_point(16'h0000, 16'h0000, 16'h0000);
        drain();
        set_light(KIND_UNUSED, 16'h0000, 16'hFFFF, 16'h0000, '1, '1, '0, '0);
        send_point(16'h0000, 16'hFFFF, 16'h0000);
        drain();

        // Spot along x, soft cone, then hard step with inner below outer
        set_light(lie_pkg::KIND_SPOT, 16'h0100, 16'h0200, 16'h0300, {16'h0, 16'h0, 16'h7FFF},
                  {16'h0, 16'h0, 16'h4000}, 16'd15000, 16'd8000);
        send_point(16'h7FFF, 16'h0000, 16'h0000);
        send_point(16'h0000, 16'h0100, 16'h0000);
        send_point(16'h7000, 16'h0200, 16'h0000);
        send_point(16'h7E00, 16'h0100, 16'h0080);
        send_point(16'h8000, 16'h0000, 16'h0000);
        drain();
        set_light(lie_pkg::KIND_SPOT, 16'hFFFF, 16'hFFFF, 16'hFFFF, {16'h0, 16'h0, 16'h8000},
                  {16'h0, 16'h0, 16'hC000}, 16'hC000, 16'h4000);
        send_point(16'h7FFF, 16'h0000, 16'h0000);
        send_point(16'h8000, 16'h0000, 16'h0001);
        send_point(16'h8100, 16'h0000, 16'h0000);
        send_point(16'h8000, 16'h0000, 16'h0000);
        drain();

        // Random settings, each with a run of points
        for (int ph = 0; ph < 14; ph++) begin
            rpos = ($urandom_range(2) == 0) ? {16'($urandom), 16'($urandom), 16'($urandom)}
                 : {16'($signed(10'($urandom))), 16'($signed(10'($urandom))),
                    16'($signed(10'($urandom)))};
            set_light(($urandom_range(5) == 0) ? 2'($urandom) : 2'($urandom_range(2, 1)),
                      rand_lum(), rand_lum(), rand_lum(), rpos, rand_dir(),
                      rand_cos(), rand_cos());
            no_gaps = (ph >= 12);
            for (int n = 0; n < 140; n++) begin
                rand_point(rpos);
                if (ph == 5 && n == 70) drain();
            end
            drain();
        end

        repeat (lie_pkg::LATENCY + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== light_intensity_estimator_unit.f =====
rtl/lie_pkg.sv
rtl/lie_cfg.sv
rtl/lie_front.sv
rtl/lie_sqrt.sv
rtl/lie_spot.sv
rtl/lie_div.sv
rtl/light_intensity_estimator_unit.sv
tb/testbench.sv
